[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL. They expect i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define AKF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define AKF_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/akf_pkg.sv]
package akf_pkg;

    typedef logic [5:0] t_addr;
    typedef logic signed [47:0] t_q;

    localparam int MEM_DEPTH = 48;
    localparam int P_CNT = 16;
    localparam int PROG_LEN = 135;
    localparam int PC_W = 8;
    localparam int PADDR_W = 4;
    localparam int DIV_STEPS = 49;
    localparam logic [PC_W-1:0] UPD_PC = 8'd75;

    localparam t_q QMAX = 48'sh7FFF_FFFF_FFFF;
    localparam t_q QMIN = 48'sh8000_0000_0000;
    localparam t_q ONE_Q = 48'sd16777216;
    localparam t_q QCOV_LO = 48'sd167772;
    localparam t_q QCOV_HI = 48'sd8388608;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_BARO_NOISE = 2'd0;
    localparam logic [1:0] REG_ABIAS_DRIFT = 2'd1;
    localparam logic [1:0] REG_BBIAS_DRIFT = 2'd2;

    // Operand space: covariance at 0..15, scratch up to 47, then state and inputs.
    localparam t_addr A_ACC = 6'd24;
    localparam t_addr A_DTSQ = 6'd25;
    localparam t_addr A_D2H = 6'd26;
    localparam t_addr A_D3H = 6'd27;
    localparam t_addr A_D4Q = 6'd28;
    localparam t_addr A_Q = 6'd29;
    localparam t_addr A_NDT = 6'd30;
    localparam t_addr A_ND2H = 6'd31;
    localparam t_addr A_T = 6'd32;
    localparam t_addr A_M = 6'd33;
    localparam t_addr A_SINV = 6'd34;
    localparam t_addr A_S = 6'd35;
    localparam t_addr A_KG0 = 6'd36;
    localparam t_addr A_HP0 = 6'd40;
    localparam t_addr A_H = 6'd48;
    localparam t_addr A_V = 6'd49;
    localparam t_addr A_AB = 6'd50;
    localparam t_addr A_PB = 6'd51;
    localparam t_addr A_INNOV = 6'd52;
    localparam t_addr A_AIN = 6'd53;
    localparam t_addr A_DTIN = 6'd54;
    localparam t_addr A_ZIN = 6'd55;
    localparam t_addr A_RVAR = 6'd56;
    localparam t_addr A_ABD = 6'd57;
    localparam t_addr A_BBD = 6'd58;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_HALF, OP_NEG, OP_QDIV, OP_RECIP, OP_END
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RDA, ST_RDB, ST_EXEC, ST_WAIT, ST_OUT
    } t_state;

    typedef struct packed {
        t_op   op;
        t_addr a;
        t_addr b;
        t_addr d;
    } t_instr;

    typedef t_instr [PROG_LEN-1:0] t_prog;

    typedef struct packed {
        logic start;
        t_op  op;
        t_q   a;
        t_q   b;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic skip;
        logic sat;
        t_q   res;
    } t_alu_rsp;

    function automatic t_addr padr(input int r, input int c);
        return t_addr'(r * 4 + c);
    endfunction

    function automatic t_instr mk(input t_op op, input t_addr a, input t_addr b,
                                  input t_addr d);
        t_instr ins;
        ins.op = op;
        ins.a = a;
        ins.b = b;
        ins.d = d;
        return ins;
    endfunction

    // Predict program from 0, update program from UPD_PC. The covariance
    // products are done in place: column by column for F*P, then row by row.
    function automatic t_prog build_prog();
        t_prog p;
        int n;
        p = '0;
        n = 0;
        p[n] = mk(OP_SUB, A_AIN, A_AB, A_ACC); n++;
        p[n] = mk(OP_MUL, A_DTIN, A_DTIN, A_DTSQ); n++;
        p[n] = mk(OP_HALF, A_DTSQ, A_DTSQ, A_D2H); n++;
        p[n] = mk(OP_MUL, A_D2H, A_DTIN, A_D3H); n++;
        p[n] = mk(OP_MUL, A_D2H, A_D2H, A_D4Q); n++;
        p[n] = mk(OP_QDIV, A_ACC, A_ACC, A_Q); n++;
        p[n] = mk(OP_NEG, A_DTIN, A_DTIN, A_NDT); n++;
        p[n] = mk(OP_NEG, A_D2H, A_D2H, A_ND2H); n++;
        p[n] = mk(OP_MUL, A_V, A_DTIN, A_T); n++;
        p[n] = mk(OP_MUL, A_ACC, A_D2H, A_M); n++;
        p[n] = mk(OP_ADD, A_T, A_M, A_T); n++;
        p[n] = mk(OP_ADD, A_H, A_T, A_H); n++;
        p[n] = mk(OP_MUL, A_ACC, A_DTIN, A_M); n++;
        p[n] = mk(OP_ADD, A_V, A_M, A_V); n++;
        for (int c = 0; c < 4; c++) begin
            p[n] = mk(OP_MUL, A_DTIN, padr(1, c), A_M); n++;
            p[n] = mk(OP_ADD, padr(0, c), A_M, A_T); n++;
            p[n] = mk(OP_MUL, A_ND2H, padr(2, c), A_M); n++;
            p[n] = mk(OP_ADD, A_T, A_M, padr(0, c)); n++;
            p[n] = mk(OP_MUL, A_NDT, padr(2, c), A_M); n++;
            p[n] = mk(OP_ADD, padr(1, c), A_M, padr(1, c)); n++;
        end
        for (int r = 0; r < 4; r++) begin
            p[n] = mk(OP_MUL, padr(r, 1), A_DTIN, A_M); n++;
            p[n] = mk(OP_ADD, padr(r, 0), A_M, A_T); n++;
            p[n] = mk(OP_MUL, padr(r, 2), A_ND2H, A_M); n++;
            p[n] = mk(OP_ADD, A_T, A_M, padr(r, 0)); n++;
            p[n] = mk(OP_MUL, padr(r, 2), A_NDT, A_M); n++;
            p[n] = mk(OP_ADD, padr(r, 1), A_M, padr(r, 1)); n++;
        end
        p[n] = mk(OP_MUL, A_D4Q, A_Q, A_M); n++;
        p[n] = mk(OP_ADD, padr(0, 0), A_M, padr(0, 0)); n++;
        p[n] = mk(OP_MUL, A_D3H, A_Q, A_M); n++;
        p[n] = mk(OP_ADD, padr(0, 1), A_M, padr(0, 1)); n++;
        p[n] = mk(OP_MUL, A_D3H, A_Q, A_M); n++;
        p[n] = mk(OP_ADD, padr(1, 0), A_M, padr(1, 0)); n++;
        p[n] = mk(OP_MUL, A_DTSQ, A_Q, A_M); n++;
        p[n] = mk(OP_ADD, padr(1, 1), A_M, padr(1, 1)); n++;
        p[n] = mk(OP_MUL, A_ABD, A_DTIN, A_M); n++;
        p[n] = mk(OP_ADD, padr(2, 2), A_M, padr(2, 2)); n++;
        p[n] = mk(OP_MUL, A_BBD, A_DTIN, A_M); n++;
        p[n] = mk(OP_ADD, padr(3, 3), A_M, padr(3, 3)); n++;
        p[n] = mk(OP_END, A_T, A_T, A_T); n++;
        // Update program.
        p[n] = mk(OP_SUB, A_ZIN, A_H, A_T); n++;
        p[n] = mk(OP_SUB, A_T, A_PB, A_INNOV); n++;
        p[n] = mk(OP_ADD, padr(0, 0), padr(0, 3), A_T); n++;
        p[n] = mk(OP_ADD, A_T, padr(3, 0), A_T); n++;
        p[n] = mk(OP_ADD, A_T, padr(3, 3), A_T); n++;
        p[n] = mk(OP_ADD, A_T, A_RVAR, A_S); n++;
        p[n] = mk(OP_RECIP, A_S, A_S, A_SINV); n++;
        for (int r = 0; r < 4; r++) begin
            p[n] = mk(OP_ADD, padr(r, 0), padr(r, 3), A_T); n++;
            p[n] = mk(OP_MUL, A_T, A_SINV, t_addr'(A_KG0 + r)); n++;
        end
        for (int r = 0; r < 4; r++) begin
            p[n] = mk(OP_MUL, t_addr'(A_KG0 + r), A_INNOV, A_M); n++;
            p[n] = mk(OP_ADD, t_addr'(A_H + r), A_M, t_addr'(A_H + r)); n++;
        end
        for (int c = 0; c < 4; c++) begin
            p[n] = mk(OP_ADD, padr(0, c), padr(3, c), t_addr'(A_HP0 + c)); n++;
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                p[n] = mk(OP_MUL, t_addr'(A_KG0 + r), t_addr'(A_HP0 + c), A_M); n++;
                p[n] = mk(OP_SUB, padr(r, c), A_M, padr(r, c)); n++;
            end
        end
        p[n] = mk(OP_END, A_T, A_T, A_T);
        return p;
    endfunction

    localparam t_prog PROG = build_prog();

    // Covariance value of an entry that has not been written since reset.
    function automatic t_q p_init(input logic [3:0] idx);
        t_q v;
        case (idx)
            4'd0:    v = ONE_Q;
            4'd5:    v = ONE_Q;
            4'd10:   v = 48'sd1677721600000;
            4'd15:   v = 48'sd4194304;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/akf_alu.sv]
module akf_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  akf_pkg::t_alu_req i_req,
    output akf_pkg::t_alu_rsp o_rsp
);

    // The noise scale |a|/50 only matters below the upper clamp, where the
    // rounded numerator fits in 29 bits and ceil(2^35/50) divides exactly.
    localparam logic [58:0] Q_RECIP = 59'd687194768;
    localparam logic [48:0] Q_HI_NUM = 49'd419430400;

    logic        r_busy, r_is_div, r_is_q, r_done, r_skip, r_sat;
    logic [5:0]  r_cnt;
    logic [47:0] r_ma, r_mb, r_prod, r_den, r_rem;
    logic        r_neg, r_pvld, r_ovf;
    logic [1:0]  r_pidx;
    logic [50:0] r_acc;
    logic [48:0] r_num, r_quo;
    logic [58:0] r_qprod;
    akf_pkg::t_q r_res;

    logic signed [48:0] sa, sb, add49, sub49, neg49;
    logic [47:0] mag_a, mag_b, prod_c;
    logic [23:0] mx, my;
    logic [48:0] trial, diff;
    logic        ge;
    logic [23:0] q_quo;
    akf_pkg::t_q mul_res, div_res, q_res;
    logic        mul_sat, div_sat;

    function automatic logic [48:0] sat49(input logic signed [48:0] s);
        // Returns {flag, value} with the value clipped to 48 bits.
        if (s[48] != s[47]) begin
            return s[48] ? {1'b1, akf_pkg::QMIN} : {1'b1, akf_pkg::QMAX};
        end
        return {1'b0, s[47:0]};
    endfunction

    always_comb begin
        sa = {i_req.a[47], i_req.a};
        sb = {i_req.b[47], i_req.b};
        add49 = sa + sb;
        sub49 = sa - sb;
        neg49 = 49'sd0 - sa;
        mag_a = i_req.a[47] ? 48'(-i_req.a) : 48'(i_req.a);
        mag_b = i_req.b[47] ? 48'(-i_req.b) : 48'(i_req.b);
    end

    // One 24x24 multiplier is walked over the four partial products.
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin mx = r_ma[47:24]; my = r_mb[47:24]; end
            2'd1:    begin mx = r_ma[47:24]; my = r_mb[23:0];  end
            2'd2:    begin mx = r_ma[23:0];  my = r_mb[47:24]; end
            default: begin mx = r_ma[23:0];  my = r_mb[23:0];  end
        endcase
        prod_c = 48'(mx) * 48'(my);
    end

    always_comb begin
        mul_sat = 1'b0;
        if (r_ovf) begin
            mul_sat = 1'b1;
            mul_res = r_neg ? akf_pkg::QMIN : akf_pkg::QMAX;
        end else if (r_neg) begin
            if (r_acc > 51'h0_8000_0000_0000) begin
                mul_sat = 1'b1;
                mul_res = akf_pkg::QMIN;
            end else begin
                mul_res = 48'(-r_acc);
            end
        end else if (r_acc > 51'h0_7FFF_FFFF_FFFF) begin
            mul_sat = 1'b1;
            mul_res = akf_pkg::QMAX;
        end else begin
            mul_res = r_acc[47:0];
        end
    end

    always_comb begin
        trial = {r_rem, r_num[48]};
        diff = trial - {1'b0, r_den};
        ge = trial >= {1'b0, r_den};
        div_sat = 1'b0;
        if (r_quo > 49'(akf_pkg::QMAX)) begin
            div_sat = 1'b1;
            div_res = akf_pkg::QMAX;
        end else begin
            div_res = r_quo[47:0];
        end
    end

    always_comb begin
        q_quo = r_qprod[58:35];
        if (r_num >= Q_HI_NUM) begin
            q_res = akf_pkg::QCOV_HI;
        end else if ({24'b0, q_quo} < akf_pkg::QCOV_LO) begin
            q_res = akf_pkg::QCOV_LO;
        end else begin
            q_res = {24'b0, q_quo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_skip <= 1'b0;
            r_sat <= 1'b0;
            r_pvld <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_skip <= 1'b0;
            r_sat <= 1'b0;
            if (i_req.start) begin
                r_cnt <= '0;
                case (i_req.op)
                    akf_pkg::OP_ADD: begin
                        {r_sat, r_res} <= sat49(add49);
                        r_done <= 1'b1;
                    end
                    akf_pkg::OP_SUB: begin
                        {r_sat, r_res} <= sat49(sub49);
                        r_done <= 1'b1;
                    end
                    akf_pkg::OP_NEG: begin
                        {r_sat, r_res} <= sat49(neg49);
                        r_done <= 1'b1;
                    end
                    akf_pkg::OP_HALF: begin
                        r_res <= i_req.a >>> 1;
                        r_done <= 1'b1;
                    end
                    akf_pkg::OP_MUL: begin
                        r_ma <= mag_a;
                        r_mb <= mag_b;
                        r_neg <= i_req.a[47] ^ i_req.b[47];
                        r_acc <= '0;
                        r_ovf <= 1'b0;
                        r_pvld <= 1'b0;
                        r_is_div <= 1'b0;
                        r_is_q <= 1'b0;
                        r_busy <= 1'b1;
                    end
                    akf_pkg::OP_QDIV: begin
                        r_num <= 49'(mag_a) + 49'd25;
                        r_is_div <= 1'b0;
                        r_is_q <= 1'b1;
                        r_busy <= 1'b1;
                    end
                    akf_pkg::OP_RECIP: begin
                        if (i_req.a[47] || i_req.a == '0) begin
                            // A non-positive innovation variance leaves the state alone.
                            r_done <= 1'b1;
                            r_skip <= 1'b1;
                            r_sat <= 1'b1;
                        end else begin
                            r_num <= {1'b1, 48'b0} + {2'b0, i_req.a[47:1]};
                            r_den <= i_req.a;
                            r_rem <= '0;
                            r_quo <= '0;
                            r_is_div <= 1'b1;
                            r_is_q <= 1'b0;
                            r_busy <= 1'b1;
                        end
                    end
                    default: begin
                        r_done <= 1'b1;
                    end
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_is_q) begin
                    if (r_cnt == 6'd0) begin
                        r_qprod <= 59'(r_num[28:0]) * Q_RECIP;
                    end else begin
                        r_res <= q_res;
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end
                end else if (r_is_div) begin
                    if (r_cnt < 6'(akf_pkg::DIV_STEPS)) begin
                        r_rem <= ge ? diff[47:0] : trial[47:0];
                        r_quo <= {r_quo[47:0], ge};
                        r_num <= {r_num[47:0], 1'b0};
                    end else begin
                        r_res <= div_res;
                        r_sat <= div_sat;
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end
                end else begin
                    if (r_cnt < 6'd4) begin
                        r_prod <= prod_c;
                        r_pidx <= r_cnt[1:0];
                        r_pvld <= 1'b1;
                    end else begin
                        r_pvld <= 1'b0;
                    end
                    if (r_pvld) begin
                        case (r_pidx)
                            2'd0: begin
                                if (r_prod[47:24] != '0) begin
                                    r_ovf <= 1'b1;
                                end
                                r_acc <= r_acc + 51'({r_prod[23:0], 24'b0});
                            end
                            2'd3: begin
                                r_acc <= r_acc + 51'(r_prod[47:24]) + 51'(r_prod[23]);
                            end
                            default: begin
                                r_acc <= r_acc + 51'(r_prod);
                            end
                        endcase
                    end
                    if (r_cnt == 6'd5) begin
                        r_res <= mul_res;
                        r_sat <= mul_sat;
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        o_rsp.skip = r_skip;
        o_rsp.sat = r_sat;
        o_rsp.res = r_res;
    end

endmodule

[rtl/core/altitude_kalman_filter4.sv]
// Four-state altitude Kalman filter (altitude, velocity, accelerometer bias,
// barometer bias) with a 4x4 covariance, in Q24.24 fixed point internally.
// Input channel: i_in_valid/o_in_ready carry one transaction per item; i_func
// selects a predict (uses i_accel, i_dt) or a barometer update (uses i_baro_alt).
// Output channel: o_out_valid/i_out_ready return one result per item with the
// new estimates, the innovation (zero for predict) and a saturation flag.
// Items run one at a time through a small microprogram on one shared unit:
// a 24x24 multiplier used four times per product, a one-bit-per-cycle
// divider for the reciprocal of the innovation variance and a reciprocal
// multiply that scales the process noise. o_in_ready is low from acceptance
// until the result is loaded into the output register; it is high only while idle.
// A finished result sits in the output register; the next item can be
// accepted while it waits, but that item's result is held back until the
// receiver takes the earlier one.
// Reset clears the estimates, restores the covariance to its starting
// diagonal and the configuration registers to their defaults. The APB port
// (byte addresses 0, 4, 8) should only be written while the block is idle.
`include "assert_macros.svh"

module altitude_kalman_filter4 (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_func,
    input  logic signed [31:0]           i_accel,
    input  logic [16:0]                  i_dt,
    input  logic signed [31:0]           i_baro_alt,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [31:0]           o_altitude,
    output logic signed [31:0]           o_velocity,
    output logic signed [31:0]           o_accel_bias_est,
    output logic signed [31:0]           o_baro_bias_est,
    output logic signed [31:0]           o_innov,
    output logic                         o_saturated,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [akf_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    akf_pkg::t_state r_state, n_state;
    logic [akf_pkg::PC_W-1:0] r_pc;
    akf_pkg::t_instr instr;

    logic [31:0] r_cfg_rvar, r_cfg_abd, r_cfg_bbd;
    logic signed [31:0] r_accel, r_baro;
    logic [16:0] r_dt;

    akf_pkg::t_q r_h, r_v, r_ab, r_pb, r_innov, r_opa;
    logic r_sat;

    akf_pkg::t_q mem [akf_pkg::MEM_DEPTH];
    logic [akf_pkg::P_CNT-1:0] r_pvld;
    akf_pkg::t_q r_mem_q, r_src_q, src_val, rd_data;
    logic r_rd_mem;
    akf_pkg::t_addr rd_addr, mem_raddr;
    logic rd_is_mem, rd_is_init;

    akf_pkg::t_alu_req alu_req;
    akf_pkg::t_alu_rsp alu_rsp;

    logic accept, wr_en, out_load, cfg_wr;

    logic signed [31:0] r_o_alt, r_o_vel, r_o_ab, r_o_pb, r_o_innov;
    logic r_o_sat, r_o_valid;
    logic [32:0] cv_h, cv_v, cv_ab, cv_pb, cv_in;

    akf_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    // Q24.24 to Q16.16 with rounding; returns {clipped, value}.
    function automatic logic [32:0] to_port(input akf_pkg::t_q x);
        logic signed [48:0] s;
        logic signed [40:0] y;
        s = {x[47], x} + 49'sd128;
        y = s[48:8];
        if (y > 41'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end
        if (y < -41'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, y[31:0]};
    endfunction

    assign instr = akf_pkg::PROG[r_pc];
    assign accept = i_in_valid && o_in_ready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        case (r_state)
            akf_pkg::ST_IDLE: n_state = accept ? akf_pkg::ST_RDA : akf_pkg::ST_IDLE;
            akf_pkg::ST_RDA:
                n_state = (instr.op == akf_pkg::OP_END) ? akf_pkg::ST_OUT : akf_pkg::ST_RDB;
            akf_pkg::ST_RDB:  n_state = akf_pkg::ST_EXEC;
            akf_pkg::ST_EXEC: n_state = akf_pkg::ST_WAIT;
            akf_pkg::ST_WAIT: begin
                if (!alu_rsp.done) begin
                    n_state = akf_pkg::ST_WAIT;
                end else if (alu_rsp.skip) begin
                    n_state = akf_pkg::ST_OUT;
                end else begin
                    n_state = akf_pkg::ST_RDA;
                end
            end
            akf_pkg::ST_OUT: n_state = out_load ? akf_pkg::ST_IDLE : akf_pkg::ST_OUT;
            default: n_state = akf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == akf_pkg::ST_IDLE);
        rd_addr = (r_state == akf_pkg::ST_RDB) ? instr.b : instr.a;
        alu_req.start = (r_state == akf_pkg::ST_EXEC);
        alu_req.op = instr.op;
        alu_req.a = r_opa;
        alu_req.b = rd_data;
        wr_en = (r_state == akf_pkg::ST_WAIT) && alu_rsp.done && !alu_rsp.skip;
        out_load = (r_state == akf_pkg::ST_OUT) && (!r_o_valid || i_out_ready);
    end

    // Operand read: scratch memory, covariance defaults, state, inputs, config.
    always_comb begin
        rd_is_mem = rd_addr < 6'(akf_pkg::MEM_DEPTH);
        rd_is_init = (rd_addr < 6'(akf_pkg::P_CNT)) && !r_pvld[rd_addr[3:0]];
        mem_raddr = rd_is_mem ? rd_addr : '0;
        case (rd_addr)
            akf_pkg::A_H:     src_val = r_h;
            akf_pkg::A_V:     src_val = r_v;
            akf_pkg::A_AB:    src_val = r_ab;
            akf_pkg::A_PB:    src_val = r_pb;
            akf_pkg::A_INNOV: src_val = r_innov;
            akf_pkg::A_AIN:   src_val = {{8{r_accel[31]}}, r_accel, 8'b0};
            akf_pkg::A_DTIN:  src_val = {23'b0, r_dt, 8'b0};
            akf_pkg::A_ZIN:   src_val = {{8{r_baro[31]}}, r_baro, 8'b0};
            akf_pkg::A_RVAR:  src_val = {8'b0, r_cfg_rvar, 8'b0};
            akf_pkg::A_ABD:   src_val = {8'b0, r_cfg_abd, 8'b0};
            akf_pkg::A_BBD:   src_val = {8'b0, r_cfg_bbd, 8'b0};
            default:          src_val = akf_pkg::p_init(rd_addr[3:0]);
        endcase
        rd_data = r_rd_mem ? r_mem_q : r_src_q;
    end

    always_ff @(posedge i_clk) begin
        r_mem_q <= mem[mem_raddr];
        r_src_q <= src_val;
        r_rd_mem <= rd_is_mem && !rd_is_init;
        if (wr_en && instr.d < 6'(akf_pkg::MEM_DEPTH)) begin
            mem[instr.d] <= alu_rsp.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= akf_pkg::ST_IDLE;
            r_pc <= '0;
            r_pvld <= '0;
            r_h <= '0;
            r_v <= '0;
            r_ab <= '0;
            r_pb <= '0;
            r_innov <= '0;
            r_sat <= 1'b0;
            r_cfg_rvar <= 32'd65536;
            r_cfg_abd <= 32'd655;
            r_cfg_bbd <= 32'd655;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (paddr[3:2])
                    akf_pkg::REG_BARO_NOISE:  r_cfg_rvar <= pwdata;
                    akf_pkg::REG_ABIAS_DRIFT: r_cfg_abd <= pwdata;
                    akf_pkg::REG_BBIAS_DRIFT: r_cfg_bbd <= pwdata;
                    default: ;
                endcase
            end
            if (accept) begin
                r_accel <= i_accel;
                r_dt <= i_dt;
                r_baro <= i_baro_alt;
                r_pc <= i_func ? akf_pkg::UPD_PC : '0;
                r_innov <= '0;
                r_sat <= 1'b0;
            end
            if (r_state == akf_pkg::ST_RDB) begin
                r_opa <= rd_data;
            end
            if (r_state == akf_pkg::ST_WAIT && alu_rsp.done) begin
                r_sat <= r_sat | alu_rsp.sat;
                r_pc <= r_pc + 1'b1;
            end
            if (wr_en) begin
                if (instr.d < 6'(akf_pkg::P_CNT)) begin
                    r_pvld[instr.d[3:0]] <= 1'b1;
                end
                case (instr.d)
                    akf_pkg::A_H:     r_h <= alu_rsp.res;
                    akf_pkg::A_V:     r_v <= alu_rsp.res;
                    akf_pkg::A_AB:    r_ab <= alu_rsp.res;
                    akf_pkg::A_PB:    r_pb <= alu_rsp.res;
                    akf_pkg::A_INNOV: r_innov <= alu_rsp.res;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        cv_h = to_port(r_h);
        cv_v = to_port(r_v);
        cv_ab = to_port(r_ab);
        cv_pb = to_port(r_pb);
        cv_in = to_port(r_innov);
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_alt <= cv_h[31:0];
            r_o_vel <= cv_v[31:0];
            r_o_ab <= cv_ab[31:0];
            r_o_pb <= cv_pb[31:0];
            r_o_innov <= cv_in[31:0];
            r_o_sat <= r_sat | cv_h[32] | cv_v[32] | cv_ab[32] | cv_pb[32] | cv_in[32];
        end
    end

    always_comb begin
        case (paddr[3:2])
            akf_pkg::REG_BARO_NOISE:  prdata = r_cfg_rvar;
            akf_pkg::REG_ABIAS_DRIFT: prdata = r_cfg_abd;
            akf_pkg::REG_BBIAS_DRIFT: prdata = r_cfg_bbd;
            default:                  prdata = '0;
        endcase
    end

    assign o_out_valid = r_o_valid;
    assign o_altitude = r_o_alt;
    assign o_velocity = r_o_vel;
    assign o_accel_bias_est = r_o_ab;
    assign o_baro_bias_est = r_o_pb;
    assign o_innov = r_o_innov;
    assign o_saturated = r_o_sat;

    `AKF_ASSERT(a_busy_after_accept, accept |=> !o_in_ready, "ready right after an accepted transaction")
    `AKF_NEVER(a_done_out_of_wait, alu_rsp.done && r_state != akf_pkg::ST_WAIT, "unit finished with no operation pending")
    `AKF_NEVER(a_pc_range, r_pc >= akf_pkg::PC_W'(akf_pkg::PROG_LEN), "program counter ran off the program")
    `AKF_ASSERT(a_result_from_out, $rose(r_o_valid) |-> $past(r_state) == akf_pkg::ST_OUT, "result raised outside the output step")

endmodule
